// ----- rtl/integer_to_ascii_formatter_assert.svh -----
// Assertion macros shared by the formatter RTL.
`ifndef INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ITAF_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ITAF_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

// ----- rtl/itaf_pkg.sv -----
// Types, codes and helpers shared by the integer-to-ASCII formatter.
package itaf_pkg;

   localparam int unsigned VALUE_W   = 64;
   localparam int unsigned DIG_W     = 4;
   localparam int unsigned OCT_W     = 3;
   localparam int unsigned NSLOT     = 22;
   localparam int unsigned SLOT_BITS = NSLOT * DIG_W;
   localparam int unsigned BITCNT_W  = $clog2(VALUE_W);
   localparam int unsigned SCAN_W    = $clog2(NSLOT);
   localparam int unsigned NSIG_W    = $clog2(NSLOT + 1);
   localparam int unsigned PTR_DIGITS = 16;

   localparam logic [2:0] OP_SDEC = 3'd0;
   localparam logic [2:0] OP_UDEC = 3'd1;
   localparam logic [2:0] OP_OCT  = 3'd2;
   localparam logic [2:0] OP_HEXL = 3'd3;
   localparam logic [2:0] OP_HEXU = 3'd4;
   localparam logic [2:0] OP_PTR  = 3'd5;

   localparam logic [1:0] SIZE_32 = 2'd0;
   localparam logic [1:0] SIZE_16 = 2'd1;
   localparam logic [1:0] SIZE_64 = 2'd2;

   localparam int unsigned FLAG_LEFT  = 0;
   localparam int unsigned FLAG_PLUS  = 1;
   localparam int unsigned FLAG_SPACE = 2;
   localparam int unsigned FLAG_ZERO  = 3;
   localparam int unsigned FLAG_ALT   = 4;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_X_UP  = 8'h58;
   localparam logic [7:0] CH_X_LOW = 8'h78;
   localparam logic [7:0] CH_A_UP  = 8'h41;
   localparam logic [7:0] CH_A_LOW = 8'h61;

   typedef enum logic [1:0] {
      RADIX_DEC,
      RADIX_OCT,
      RADIX_HEX
   } radix_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_CONV,
      ST_SCAN,
      ST_SIZE,
      ST_ARM,
      ST_LEAD,
      ST_PREFIX,
      ST_ZPAD,
      ST_DIGITS,
      ST_TRAIL,
      ST_EMPTY
   } state_type;

   // Control of the digit register.
   typedef struct packed {
      logic      load;
      radix_type radix;
      logic      dabble;
      logic      shift;
      logic      bit_in;
   } dig_ctl_type;

   function automatic logic [7:0] digit_char(input logic [DIG_W-1:0] d, input logic upper);
      logic [7:0] base;
      base = upper ? CH_A_UP : CH_A_LOW;
      if (d < 4'd10) begin
         return CH_ZERO + 8'(d);
      end
      return base + 8'(d) - 8'd10;
   endfunction

endpackage

// ----- rtl/itaf_digit_reg.sv -----
// Digit register: double-dabble conversion, radix load and slot shifting.
module itaf_digit_reg (
   input  logic                          clock,
   input  itaf_pkg::dig_ctl_type         ctl,
   input  logic [itaf_pkg::VALUE_W-1:0]  mag,
   output logic [itaf_pkg::DIG_W-1:0]    top_digit
);
   import itaf_pkg::*;

   logic [SLOT_BITS-1:0] dig_ff;
   logic [SLOT_BITS-1:0] dig_in;
   logic [SLOT_BITS-1:0] oct_val;
   logic [SLOT_BITS-1:0] hex_val;
   logic [SLOT_BITS-1:0] dabble_val;
   logic [VALUE_W+1:0]   mag_pad;

   assign mag_pad = {2'b00, mag};
   assign hex_val = {{(SLOT_BITS - VALUE_W){1'b0}}, mag};

   always_comb begin
      oct_val    = '0;
      dabble_val = '0;
      for (int k = 0; k < NSLOT; k++) begin
         oct_val[k*DIG_W +: DIG_W] = {1'b0, mag_pad[k*OCT_W +: OCT_W]};
         // Each BCD digit of five or more is corrected before the shift.
         if (dig_ff[k*DIG_W +: DIG_W] >= 4'd5) begin
            dabble_val[k*DIG_W +: DIG_W] = dig_ff[k*DIG_W +: DIG_W] + 4'd3;
         end else begin
            dabble_val[k*DIG_W +: DIG_W] = dig_ff[k*DIG_W +: DIG_W];
         end
      end
   end

   always_comb begin
      dig_in = dig_ff;
      if (ctl.load) begin
         case (ctl.radix)
            RADIX_OCT: dig_in = oct_val;
            RADIX_HEX: dig_in = hex_val;
            default:   dig_in = '0;
         endcase
      end else if (ctl.dabble) begin
         dig_in = {dabble_val[SLOT_BITS-2:0], ctl.bit_in};
      end else if (ctl.shift) begin
         dig_in = {dig_ff[SLOT_BITS-DIG_W-1:0], {DIG_W{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      dig_ff <= dig_in;
   end

   assign top_digit = dig_ff[SLOT_BITS-1 -: DIG_W];

endmodule

// ----- rtl/integer_to_ascii_formatter.sv -----
// Top level of the integer-to-ASCII formatter: argument decode, sequencer and output.
// After the start transfer an item passes through load, double-dabble conversion (decimal
// only, one step per argument bit: 16, 32 or 64), a scan for the top significant digit,
// field sizing and the character phases.
// One character leaves per cycle. The receiver cannot stall.
// Synchronous reset returns the sequencer to idle; no other state is kept between items.
`include "integer_to_ascii_formatter_assert.svh"

module integer_to_ascii_formatter #(
   parameter int MAX_WIDTH     = 48,
   parameter int MAX_PRECISION = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_op,
   input  logic [63:0] req_value,
   input  logic [1:0]  req_size,
   input  logic [4:0]  req_flags,
   input  logic [5:0]  req_width,
   input  logic [6:0]  req_precision,
   output logic        rsp_valid,
   output logic [7:0]  rsp_character,
   output logic        rsp_has_char,
   output logic        rsp_last
);
   import itaf_pkg::*;

   localparam int MAX_FIELD = (MAX_WIDTH > MAX_PRECISION + 2) ? MAX_WIDTH : MAX_PRECISION + 2;
   localparam int CNT_W     = $clog2(MAX_FIELD + 1);

   state_type             state_ff, state_in;
   radix_type             radix_ff, radix_in;
   logic                  left_ff, left_in;
   logic                  zero_ff, zero_in;
   logic                  upper_ff, upper_in;
   logic [1:0]            plen_ff, plen_in;
   logic [15:0]           pre_ff, pre_in;
   logic [CNT_W-1:0]      width_ff, width_in;
   logic [CNT_W-1:0]      prec_ff, prec_in;
   logic [VALUE_W-1:0]    mag_ff, mag_in;
   logic [BITCNT_W-1:0]   bitcnt_ff, bitcnt_in;
   logic [SCAN_W-1:0]     scan_ff, scan_in;
   logic [NSIG_W-1:0]     nsig_ff, nsig_in;
   logic [CNT_W-1:0]      ndig_ff, ndig_in;
   logic [CNT_W-1:0]      pad_ff, pad_in;
   logic [CNT_W-1:0]      tot_ff, tot_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;

   dig_ctl_type           dig_ctl;
   logic [DIG_W-1:0]      top_digit;

   // Argument decode for the item at the input.
   logic                  is16, is64, neg, sign_bit;
   logic [VALUE_W-1:0]    mask, masked, mag_acc;
   logic [CNT_W-1:0]      p_sat;

   // Field planning.
   logic [CNT_W-1:0]      nsig_ext, ndig_calc, body;
   logic [CNT_W-1:0]      lead_cnt, pre_cnt, zp_cnt, tr_cnt;
   state_type             after_lead, after_prefix, after_zpad, after_digits, first_phase;
   state_type             phase_next;
   logic [CNT_W-1:0]      phase_cnt;

   itaf_digit_reg u_digits (
      .clock     (clock),
      .ctl       (dig_ctl),
      .mag       (mag_ff),
      .top_digit (top_digit)
   );

   always_comb begin
      is64     = (req_size == SIZE_64) || (req_op == OP_PTR);
      is16     = (req_size == SIZE_16) && !is64;
      mask     = is64 ? {VALUE_W{1'b1}} : (is16 ? 64'h0000_0000_0000_FFFF
                                                : 64'h0000_0000_FFFF_FFFF);
      masked   = req_value & mask;
      sign_bit = is64 ? req_value[63] : (is16 ? req_value[15] : req_value[31]);
      neg      = (req_op == OP_SDEC) && sign_bit;
      // The magnitude of a negative argument always fits in the argument width.
      mag_acc  = neg ? ((~masked & mask) + 64'd1) : masked;
      if (32'(req_precision[5:0]) > MAX_PRECISION) begin
         p_sat = CNT_W'(MAX_PRECISION);
      end else begin
         p_sat = CNT_W'(req_precision[5:0]);
      end
   end

   always_comb begin
      nsig_ext  = CNT_W'(nsig_ff);
      ndig_calc = (nsig_ext > prec_ff) ? nsig_ext : prec_ff;
      body      = ndig_calc + CNT_W'(plen_ff);
      lead_cnt  = (!left_ff && !zero_ff) ? pad_ff : '0;
      pre_cnt   = CNT_W'(plen_ff);
      zp_cnt    = (!left_ff && zero_ff) ? pad_ff : '0;
      tr_cnt    = left_ff ? pad_ff : '0;
      // Each phase hands over to the next one that has characters to send.
      after_digits = (tr_cnt != '0) ? ST_TRAIL : ST_IDLE;
      after_zpad   = (ndig_ff != '0) ? ST_DIGITS : after_digits;
      after_prefix = (zp_cnt != '0) ? ST_ZPAD : after_zpad;
      after_lead   = (pre_cnt != '0) ? ST_PREFIX : after_prefix;
      first_phase  = (lead_cnt != '0) ? ST_LEAD : after_lead;
      case (state_ff)
         ST_ARM:    phase_next = first_phase;
         ST_LEAD:   phase_next = after_lead;
         ST_PREFIX: phase_next = after_prefix;
         ST_ZPAD:   phase_next = after_zpad;
         ST_DIGITS: phase_next = after_digits;
         default:   phase_next = ST_IDLE;
      endcase
      case (phase_next)
         ST_LEAD:   phase_cnt = lead_cnt;
         ST_PREFIX: phase_cnt = pre_cnt;
         ST_ZPAD:   phase_cnt = zp_cnt;
         ST_DIGITS: phase_cnt = ndig_ff;
         ST_TRAIL:  phase_cnt = tr_cnt;
         default:   phase_cnt = '0;
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff) inside
         ST_IDLE: begin
            if (start) begin
               state_in = (req_op > OP_PTR) ? ST_EMPTY : ST_LOAD;
            end
         end
         ST_LOAD:  state_in = (radix_ff == RADIX_DEC) ? ST_CONV : ST_SCAN;
         ST_CONV: begin
            if (bitcnt_ff == '0) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (top_digit != '0 || scan_ff == '0) begin
               state_in = ST_SIZE;
            end
         end
         ST_SIZE:  state_in = ST_ARM;
         ST_ARM:   state_in = (tot_ff == '0) ? ST_EMPTY : phase_next;
         ST_LEAD, ST_PREFIX, ST_ZPAD, ST_DIGITS, ST_TRAIL: begin
            if (cnt_ff == CNT_W'(1)) begin
               state_in = phase_next;
            end
         end
         ST_EMPTY: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Outputs and digit register control.
   always_comb begin
      busy           = (state_ff != ST_IDLE);
      rsp_valid      = 1'b0;
      rsp_character  = CH_NUL;
      rsp_has_char   = 1'b1;
      rsp_last       = (tot_ff == CNT_W'(1));
      dig_ctl        = '0;
      dig_ctl.radix  = radix_ff;
      dig_ctl.bit_in = mag_ff[VALUE_W-1];
      unique case (state_ff) inside
         ST_LOAD: dig_ctl.load = 1'b1;
         ST_CONV: dig_ctl.dabble = 1'b1;
         ST_SCAN: dig_ctl.shift = (top_digit == '0);
         ST_LEAD, ST_TRAIL: begin
            rsp_valid     = 1'b1;
            rsp_character = CH_SPACE;
         end
         ST_PREFIX: begin
            rsp_valid     = 1'b1;
            rsp_character = pre_ff[15:8];
         end
         ST_ZPAD: begin
            rsp_valid     = 1'b1;
            rsp_character = CH_ZERO;
         end
         ST_DIGITS: begin
            rsp_valid = 1'b1;
            // Positions above the most significant digit are precision zeros.
            if (cnt_ff > nsig_ext) begin
               rsp_character = CH_ZERO;
            end else begin
               rsp_character = digit_char(top_digit, upper_ff);
               dig_ctl.shift = 1'b1;
            end
         end
         ST_EMPTY: begin
            rsp_valid    = 1'b1;
            rsp_has_char = 1'b0;
            rsp_last     = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Datapath next values.
   always_comb begin
      radix_in  = radix_ff;
      left_in   = left_ff;
      zero_in   = zero_ff;
      upper_in  = upper_ff;
      plen_in   = plen_ff;
      pre_in    = pre_ff;
      width_in  = width_ff;
      prec_in   = prec_ff;
      mag_in    = mag_ff;
      bitcnt_in = bitcnt_ff;
      scan_in   = scan_ff;
      nsig_in   = nsig_ff;
      ndig_in   = ndig_ff;
      pad_in    = pad_ff;
      tot_in    = tot_ff;
      cnt_in    = cnt_ff;
      unique case (state_ff) inside
         ST_IDLE: begin
            left_in  = req_flags[FLAG_LEFT];
            zero_in  = req_flags[FLAG_ZERO] && (req_op != OP_PTR);
            upper_in = (req_op == OP_HEXU) || (req_op == OP_PTR);
            if (32'(req_width) > MAX_WIDTH) begin
               width_in = CNT_W'(MAX_WIDTH);
            end else begin
               width_in = CNT_W'(req_width);
            end
            if (req_op == OP_PTR) begin
               prec_in = CNT_W'(PTR_DIGITS);
            end else if (req_precision[6]) begin
               prec_in = CNT_W'(1);
            end else if (req_op == OP_OCT && req_flags[FLAG_ALT] && p_sat != '0) begin
               prec_in = p_sat - CNT_W'(1);
            end else begin
               prec_in = p_sat;
            end
            bitcnt_in = is64 ? BITCNT_W'(63) : (is16 ? BITCNT_W'(15) : BITCNT_W'(31));
            plen_in   = 2'd0;
            pre_in    = 16'h0000;
            unique case (req_op) inside
               OP_SDEC: begin
                  radix_in = RADIX_DEC;
                  if (neg) begin
                     plen_in = 2'd1;
                     pre_in  = {CH_MINUS, CH_NUL};
                  end else if (req_flags[FLAG_PLUS]) begin
                     plen_in = 2'd1;
                     pre_in  = {CH_PLUS, CH_NUL};
                  end else if (req_flags[FLAG_SPACE]) begin
                     plen_in = 2'd1;
                     pre_in  = {CH_SPACE, CH_NUL};
                  end
               end
               OP_UDEC: radix_in = RADIX_DEC;
               OP_OCT: begin
                  radix_in = RADIX_OCT;
                  if (req_flags[FLAG_ALT]) begin
                     plen_in = 2'd1;
                     pre_in  = {CH_ZERO, CH_NUL};
                  end
               end
               OP_HEXL: begin
                  radix_in = RADIX_HEX;
                  if (req_flags[FLAG_ALT]) begin
                     plen_in = 2'd2;
                     pre_in  = {CH_ZERO, CH_X_LOW};
                  end
               end
               OP_HEXU, OP_PTR: begin
                  radix_in = RADIX_HEX;
                  if (req_flags[FLAG_ALT]) begin
                     plen_in = 2'd2;
                     pre_in  = {CH_ZERO, CH_X_UP};
                  end
               end
               default: radix_in = RADIX_HEX;
            endcase
            // Decimal arguments are left-justified so conversion starts at their top bit.
            if (radix_in == RADIX_DEC && !is64) begin
               mag_in = is16 ? {mag_acc[15:0], 48'h0} : {mag_acc[31:0], 32'h0};
            end else begin
               mag_in = mag_acc;
            end
         end
         ST_LOAD: scan_in = SCAN_W'(NSLOT - 1);
         ST_CONV: begin
            mag_in    = {mag_ff[VALUE_W-2:0], 1'b0};
            bitcnt_in = bitcnt_ff - BITCNT_W'(1);
         end
         ST_SCAN: begin
            if (top_digit != '0) begin
               nsig_in = NSIG_W'(scan_ff) + NSIG_W'(1);
            end else if (scan_ff == '0) begin
               nsig_in = '0;
            end else begin
               scan_in = scan_ff - SCAN_W'(1);
            end
         end
         ST_SIZE: begin
            ndig_in = ndig_calc;
            if (width_ff > body) begin
               pad_in = width_ff - body;
               tot_in = width_ff;
            end else begin
               pad_in = '0;
               tot_in = body;
            end
         end
         ST_ARM: cnt_in = phase_cnt;
         ST_LEAD, ST_PREFIX, ST_ZPAD, ST_DIGITS, ST_TRAIL: begin
            tot_in = tot_ff - CNT_W'(1);
            cnt_in = (cnt_ff == CNT_W'(1)) ? phase_cnt : cnt_ff - CNT_W'(1);
            if (state_ff == ST_PREFIX) begin
               pre_in = {pre_ff[7:0], CH_NUL};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      radix_ff  <= radix_in;
      left_ff   <= left_in;
      zero_ff   <= zero_in;
      upper_ff  <= upper_in;
      plen_ff   <= plen_in;
      pre_ff    <= pre_in;
      width_ff  <= width_in;
      prec_ff   <= prec_in;
      mag_ff    <= mag_in;
      bitcnt_ff <= bitcnt_in;
      scan_ff   <= scan_in;
      nsig_ff   <= nsig_in;
      ndig_ff   <= ndig_in;
      pad_ff    <= pad_in;
      tot_ff    <= tot_in;
      cnt_ff    <= cnt_in;
   end

   `ITAF_ASSERT_NOW(a_rsp_while_busy, clock, reset, rsp_valid, busy)
   `ITAF_ASSERT_NEXT(a_last_ends_item, clock, reset, rsp_valid && rsp_last, !rsp_valid && !busy)
   `ITAF_ASSERT_NEXT(a_start_sets_busy, clock, reset, start && !busy, busy)
   `ITAF_ASSERT_NOW(a_empty_is_last, clock, reset, rsp_valid && !rsp_has_char, rsp_last)

endmodule

// ----- test/integer_to_ascii_formatter_checker.sv -----
// Checker for the integer-to-ASCII formatter: predicts each field and compares every character.
module integer_to_ascii_formatter_checker #(
   parameter int MAX_WIDTH     = 48,
   parameter int MAX_PRECISION = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [2:0]  req_op,
   input  logic [63:0] req_value,
   input  logic [1:0]  req_size,
   input  logic [4:0]  req_flags,
   input  logic [5:0]  req_width,
   input  logic [6:0]  req_precision,
   input  logic        rsp_valid,
   input  logic [7:0]  rsp_character,
   input  logic        rsp_has_char,
   input  logic        rsp_last,
   output int          failures,
   output int          chars_pending
);
   import itaf_pkg::*;

   localparam int REPORT_LIMIT = 10;
   localparam int TEXT_DEPTH   = 160;

   typedef struct packed {
      logic [7:0] character;
      logic       has_char;
      logic       last;
   } field_char_type;

   field_char_type expected_chars[$];

   // Works out the whole formatted field of one request and queues its characters.
   function automatic void format_field(input logic [2:0] op, input logic [63:0] value,
                                        input logic [1:0] size, input logic [4:0] flags_in,
                                        input logic [5:0] width_in,
                                        input logic [6:0] precision_in);
      int             prec;
      int             fwidth;
      int             nbits;
      int             plen;
      int             ndig;
      int             pad;
      int             count;
      int             i;
      logic [4:0]     flags;
      logic [63:0]    mag;
      logic [63:0]    sext;
      logic [63:0]    radix;
      logic [63:0]    rem;
      logic           upper;
      logic [7:0]     prefix[0:1];
      logic [7:0]     digits[0:71];
      logic [7:0]     text[0:TEXT_DEPTH-1];
      field_char_type item;

      flags = flags_in;
      prec = int'(precision_in);
      if (precision_in[6]) begin
         prec = prec - 128;
      end
      if (prec > MAX_PRECISION) begin
         prec = MAX_PRECISION;
      end
      fwidth = int'(width_in);
      if (fwidth > MAX_WIDTH) begin
         fwidth = MAX_WIDTH;
      end
      count = 0;

      // Unknown conversions leave the text empty.
      if (op <= OP_PTR) begin
         case (size)
            SIZE_16: nbits = 16;
            SIZE_64: nbits = 64;
            default: nbits = 32;
         endcase
         if (op == OP_PTR) begin
            nbits = 64;
            prec = 16;
            flags[FLAG_ZERO] = 1'b0;
         end
         mag = (nbits == 64) ? value : (value & ((64'd1 << nbits) - 64'd1));
         radix = 64'd10;
         upper = 1'b0;
         plen = 0;
         case (op)
            OP_SDEC: begin
               if (nbits == 16) begin
                  sext = {{48{value[15]}}, value[15:0]};
               end else if (nbits == 32) begin
                  sext = {{32{value[31]}}, value[31:0]};
               end else begin
                  sext = value;
               end
               if (sext[63]) begin
                  mag = -sext;
                  prefix[0] = CH_MINUS;
                  plen = 1;
               end else begin
                  mag = sext;
                  if (flags[FLAG_PLUS]) begin
                     prefix[0] = CH_PLUS;
                     plen = 1;
                  end else if (flags[FLAG_SPACE]) begin
                     prefix[0] = CH_SPACE;
                     plen = 1;
                  end
               end
            end
            OP_OCT: begin
               radix = 64'd8;
               if (flags[FLAG_ALT]) begin
                  prefix[0] = CH_ZERO;
                  plen = 1;
                  // The leading zero of the prefix counts as one digit of precision.
                  if (prec > 0) begin
                     prec--;
                  end
               end
            end
            OP_HEXL, OP_HEXU, OP_PTR: begin
               radix = 64'd16;
               upper = (op != OP_HEXL);
               if (flags[FLAG_ALT]) begin
                  prefix[0] = CH_ZERO;
                  prefix[1] = upper ? CH_X_UP : CH_X_LOW;
                  plen = 2;
               end
            end
            default: begin
            end
         endcase
         if (prec < 0) begin
            prec = 1;
         end

         ndig = 0;
         while ((mag != 64'd0 || prec > 0) && ndig < 72) begin
            rem = mag % radix;
            if (rem < 64'd10) begin
               digits[ndig] = CH_ZERO + 8'(rem[3:0]);
            end else begin
               digits[ndig] = (upper ? CH_A_UP : CH_A_LOW) + 8'(rem[3:0]) - 8'd10;
            end
            mag = mag / radix;
            ndig++;
            prec--;
         end

         pad = fwidth - ndig - plen;
         if (pad < 0) begin
            pad = 0;
         end
         if (!flags[FLAG_LEFT] && !flags[FLAG_ZERO]) begin
            for (i = 0; i < pad; i++) begin
               text[count++] = CH_SPACE;
            end
            pad = 0;
         end
         for (i = 0; i < plen; i++) begin
            text[count++] = prefix[i];
         end
         if (!flags[FLAG_LEFT]) begin
            for (i = 0; i < pad; i++) begin
               text[count++] = CH_ZERO;
            end
         end
         for (i = ndig - 1; i >= 0; i--) begin
            text[count++] = digits[i];
         end
         if (flags[FLAG_LEFT]) begin
            for (i = 0; i < pad; i++) begin
               text[count++] = CH_SPACE;
            end
         end
      end

      if (count == 0) begin
         item.character = CH_NUL;
         item.has_char = 1'b0;
         item.last = 1'b1;
         expected_chars.push_back(item);
      end else begin
         for (i = 0; i < count; i++) begin
            item.character = text[i];
            item.has_char = 1'b1;
            item.last = (i == count - 1);
            expected_chars.push_back(item);
         end
      end
   endfunction

   always @(posedge clock) begin : monitor
      field_char_type want;
      if (reset) begin
         expected_chars.delete();
         failures = 0;
      end else begin
         // A character never belongs to a request taken at the same edge, so compare first.
         if (rsp_valid) begin
            if (expected_chars.size() == 0) begin
               failures++;
               if (failures <= REPORT_LIMIT) begin
                  $display("unexpected character: char=%h has_char=%b last=%b",
                           rsp_character, rsp_has_char, rsp_last);
               end
            end else begin
               want = expected_chars.pop_front();
               if (want.character !== rsp_character || want.has_char !== rsp_has_char ||
                   want.last !== rsp_last) begin
                  failures++;
                  if (failures <= REPORT_LIMIT) begin
                     $display("mismatch (char/has_char/last): expected %h/%b/%b, got %h/%b/%b",
                              want.character, want.has_char, want.last,
                              rsp_character, rsp_has_char, rsp_last);
                  end
               end
            end
         end
         if (start && !busy) begin
            format_field(req_op, req_value, req_size, req_flags, req_width, req_precision);
         end
      end
      chars_pending = expected_chars.size();
   end

endmodule

// ----- test/integer_to_ascii_formatter_tb.sv -----
// Testbench top for the integer-to-ASCII formatter: clock, reset, request stimulus and verdict.
module integer_to_ascii_formatter_tb;
   import itaf_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 160;
   localparam int RANDOM_ITEMS   = 236;
   localparam int MAX_WIDTH_TB   = 48;

   localparam logic [4:0] F_LEFT  = 5'd1 << FLAG_LEFT;
   localparam logic [4:0] F_PLUS  = 5'd1 << FLAG_PLUS;
   localparam logic [4:0] F_SPACE = 5'd1 << FLAG_SPACE;
   localparam logic [4:0] F_ZERO  = 5'd1 << FLAG_ZERO;
   localparam logic [4:0] F_ALT   = 5'd1 << FLAG_ALT;
   localparam logic [4:0] F_NONE  = 5'd0;
   localparam logic [6:0] PREC_NONE = 7'h7F;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [2:0]  req_op;
   logic [63:0] req_value;
   logic [1:0]  req_size;
   logic [4:0]  req_flags;
   logic [5:0]  req_width;
   logic [6:0]  req_precision;
   logic        rsp_valid;
   logic [7:0]  rsp_character;
   logic        rsp_has_char;
   logic        rsp_last;
   int          failures;
   int          chars_pending;
   int          burst_left;

   integer_to_ascii_formatter i_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_op        (req_op),
      .req_value     (req_value),
      .req_size      (req_size),
      .req_flags     (req_flags),
      .req_width     (req_width),
      .req_precision (req_precision),
      .rsp_valid     (rsp_valid),
      .rsp_character (rsp_character),
      .rsp_has_char  (rsp_has_char),
      .rsp_last      (rsp_last)
   );

   integer_to_ascii_formatter_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_op        (req_op),
      .req_value     (req_value),
      .req_size      (req_size),
      .req_flags     (req_flags),
      .req_width     (req_width),
      .req_precision (req_precision),
      .rsp_valid     (rsp_valid),
      .rsp_character (rsp_character),
      .rsp_has_char  (rsp_has_char),
      .rsp_last      (rsp_last),
      .failures      (failures),
      .chars_pending (chars_pending)
   );

   initial begin
      clock = 1'b0;
   end

   always begin
      #5 clock = ~clock;
   end

   // Presents one request, holds it until the transfer, then idles between bursts.
   task automatic send_item(input logic [2:0] op, input logic [63:0] value,
                            input logic [1:0] size, input logic [4:0] flags,
                            input logic [5:0] width, input logic [6:0] precision);
      int gap;
      @(negedge clock);
      start <= 1'b1;
      req_op <= op;
      req_value <= value;
      req_size <= size;
      req_flags <= flags;
      req_width <= width;
      req_precision <= precision;
      do begin
         @(posedge clock);
      end while (busy);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 160) : $urandom_range(0, 30);
         // Fields carry noise while no request is offered.
         for (int k = 0; k < gap; k++) begin
            @(negedge clock);
            start <= 1'b0;
            req_op <= 3'($urandom);
            req_value <= {$urandom, $urandom};
            req_size <= 2'($urandom);
            req_flags <= 5'($urandom);
            req_width <= 6'($urandom);
            req_precision <= 7'($urandom);
         end
         burst_left = $urandom_range(0, 12);
      end
   endtask

   task automatic send_random_item();
      logic [2:0]  op;
      logic [1:0]  size;
      logic [5:0]  width;
      logic [6:0]  precision;
      logic [63:0] value;
      int          pick;
      int          bits;
      pick = $urandom_range(0, 19);
      op = (pick < 19) ? 3'(pick % 6) : 3'($urandom_range(6, 7));
      pick = $urandom_range(0, 9);
      size = (pick < 9) ? 2'(pick % 3) : 2'd3;
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
         width = 6'($urandom_range(0, 24));
      end else if (pick < 9) begin
         width = 6'($urandom_range(0, MAX_WIDTH_TB));
      end else begin
         width = 6'($urandom_range(0, 63));
      end
      pick = $urandom_range(0, 19);
      if (pick < 8) begin
         precision = PREC_NONE;
      end else if (pick < 15) begin
         precision = 7'($urandom_range(0, 12));
      end else if (pick < 18) begin
         precision = 7'($urandom_range(0, 32));
      end else begin
         precision = 7'($urandom_range(0, 127));
      end
      bits = (size == SIZE_16) ? 16 : (size == SIZE_64) ? 64 : 32;
      case ($urandom_range(0, 7))
         0: value = 64'd0;
         1: value = ~64'd0;
         2: value = 64'($urandom_range(0, 300));
         3: value = (64'd1 << (bits - 1)) + 64'($urandom_range(0, 2)) - 64'd1;
         4: value = {32'd0, $urandom};
         default: value = {$urandom, $urandom};
      endcase
      send_item(op, value, size, 5'($urandom_range(0, 31)), width, precision);
   endtask

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (start && !busy) || rsp_valid) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("tb: failure");
      $finish;
   end

   initial begin : stimulus
      reset = 1'b1;
      start = 1'b0;
      req_op = OP_SDEC;
      req_value = 64'd0;
      req_size = SIZE_32;
      req_flags = F_NONE;
      req_width = 6'd0;
      req_precision = PREC_NONE;
      burst_left = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed cases: extremes, every conversion and the special rules.
      send_item(OP_SDEC, 64'd0, SIZE_32, F_NONE, 6'd0, PREC_NONE);
      send_item(OP_SDEC, 64'd0, SIZE_32, F_NONE, 6'd0, 7'd0);
      send_item(OP_SDEC, 64'h0000_0000_8000_0000, SIZE_32, F_PLUS | F_ZERO, 6'd15, PREC_NONE);
      send_item(OP_SDEC, 64'h8000_0000_0000_0000, SIZE_64, F_PLUS, 6'd0, PREC_NONE);
      send_item(OP_SDEC, 64'h1234_5678_9ABC_FFFF, SIZE_16, F_SPACE | F_LEFT, 6'd10, PREC_NONE);
      send_item(OP_SDEC, 64'd42, SIZE_32, F_PLUS | F_SPACE, 6'd6, 7'd4);
      send_item(OP_SDEC, 64'd7, SIZE_32, F_SPACE | F_ZERO, 6'd8, 7'd3);
      send_item(OP_UDEC, ~64'd0, SIZE_64, F_NONE, 6'd48, 7'd32);
      send_item(OP_UDEC, 64'hFFFF_FFFF_8000_0000, 2'd3, F_PLUS | F_ALT, 6'd0, PREC_NONE);
      send_item(OP_OCT, ~64'd0, SIZE_64, F_ALT, 6'd0, PREC_NONE);
      send_item(OP_OCT, 64'd0, SIZE_32, F_ALT, 6'd0, 7'd0);
      send_item(OP_OCT, 64'o777, SIZE_16, F_ALT | F_ZERO, 6'd9, 7'd5);
      send_item(OP_HEXL, 64'd0, SIZE_32, F_ALT, 6'd0, PREC_NONE);
      send_item(OP_HEXU, 64'hDEAD_BEEF, SIZE_32, F_ALT | F_ZERO, 6'd20, PREC_NONE);
      send_item(OP_HEXL, 64'hFEDC_BA98_7654_3210, SIZE_64, F_LEFT | F_ZERO, 6'd63, PREC_NONE);
      send_item(OP_PTR, 64'd0, SIZE_16, 5'h1F, 6'd48, 7'd3);
      send_item(OP_PTR, 64'h0123_4567_89AB_CDEF, SIZE_32, F_ZERO, 6'd30, PREC_NONE);
      send_item(3'd6, ~64'd0, SIZE_64, 5'h1F, 6'd20, 7'd5);
      send_item(3'd7, 64'd5, SIZE_32, F_NONE, 6'd0, PREC_NONE);
      send_item(OP_UDEC, 64'd12345, SIZE_32, F_NONE, 6'd0, 7'h40);
      send_item(OP_UDEC, 64'd9, SIZE_32, F_NONE, 6'd40, 7'd63);
      send_item(OP_SDEC, 64'hFFFF_FFFF_FFFF_FFFF, SIZE_32, F_ZERO, 6'd5, 7'd33);
      send_item(OP_HEXL, 64'd0, SIZE_32, F_NONE, 6'd0, 7'd0);
      send_item(OP_HEXU, 64'hABCD, SIZE_16, F_LEFT, 6'd12, 7'd8);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         send_random_item();
      end

      @(negedge clock);
      start <= 1'b0;
      while (chars_pending != 0) begin
         @(negedge clock);
      end
      // Extra characters after the last expected one would still be caught here.
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
